@@ hdl/bts_pkg.sv @@
`timescale 1ns / 1ps
package bts_pkg;

	localparam int unsigned AdcW     = 12;
	localparam int unsigned PresW    = 16;
	localparam int unsigned SecW     = 6;
	localparam int unsigned WaitW    = 4;
	localparam int unsigned PctW     = 7;
	localparam int unsigned ReasonW  = 3;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned ProdW    = PresW + PctW;

	localparam logic [PctW-1:0]  PctFull    = PctW'(100);
	localparam logic [WaitW-1:0] WaitMax    = '1;
	localparam logic [SecW-1:0]  RangeDelay = SecW'(2);

	typedef enum logic [CfgIdxW-1:0] {
		REG_BELLOWS_MIN  = 3'd0,
		REG_BELLOWS_MAX  = 3'd1,
		REG_TIMEOUT      = 3'd2,
		REG_ARM_PRESSURE = 3'd3,
		REG_DROP_PERCENT = 3'd4,
		REG_WAIT_LIMIT   = 3'd5
	} cfg_reg_t;

	typedef enum logic [ReasonW-1:0] {
		END_NONE    = 3'd0,
		END_BURST   = 3'd1,
		END_TIMEOUT = 3'd2,
		END_ABORT   = 3'd3,
		END_BFAULT  = 3'd4,
		END_LOW     = 3'd5,
		END_HIGH    = 3'd6,
		END_WFAIL   = 3'd7
	} end_reason_t;

	typedef struct packed {
		logic [AdcW-1:0]  bellows_min_adc;
		logic [AdcW-1:0]  bellows_max_adc;
		logic [SecW-1:0]  timeout_seconds;
		logic [PresW-1:0] arm_pressure;
		logic [PctW-1:0]  drop_percent;
		logic [WaitW-1:0] bellows_wait_limit;
	} cfg_t;

	typedef struct packed {
		logic             func;
		logic             tick;
		logic [AdcW-1:0]  bellows_adc;
		logic [PresW-1:0] pressure;
		logic             abort;
		logic             write_fail;
	} poll_t;

	typedef struct packed {
		logic             running;
		end_reason_t      end_reason;
		logic             specimen_valve;
		logic             bellows_valve;
		logic             sample_valid;
		logic [SecW-1:0]  sample_second;
		logic [PresW-1:0] peak_pressure;
	} result_t;

endpackage

@@ hdl/bts_if.sv @@
`timescale 1ns / 1ps
interface bts_poll_if import bts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic             tick;
	logic [AdcW-1:0]  bellows_adc;
	logic [PresW-1:0] pressure;
	logic             abort;
	logic             write_fail;

	modport source (output valid, func, tick, bellows_adc, pressure, abort, write_fail,
		input ready);
	modport sink (input valid, func, tick, bellows_adc, pressure, abort, write_fail,
		output ready);
endinterface

interface bts_result_if import bts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                running;
	logic [ReasonW-1:0]  end_reason;
	logic                specimen_valve;
	logic                bellows_valve;
	logic                sample_valid;
	logic [SecW-1:0]     sample_second;
	logic [PresW-1:0]    peak_pressure;

	modport source (output valid, running, end_reason, specimen_valve, bellows_valve,
		sample_valid, sample_second, peak_pressure, input ready);
	modport sink (input valid, running, end_reason, specimen_valve, bellows_valve,
		sample_valid, sample_second, peak_pressure, output ready);
endinterface

@@ hdl/bts_cfg.sv @@
`timescale 1ns / 1ps
module bts_cfg import bts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bellows_min_adc    <= '0;
			cfg_q.bellows_max_adc    <= '1;
			cfg_q.timeout_seconds    <= SecW'(30);
			cfg_q.arm_pressure       <= PresW'(10);
			cfg_q.drop_percent       <= PctW'(60);
			cfg_q.bellows_wait_limit <= WaitW'(5);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BELLOWS_MIN:  cfg_q.bellows_min_adc    <= cfg_wdata[AdcW-1:0];
				REG_BELLOWS_MAX:  cfg_q.bellows_max_adc    <= cfg_wdata[AdcW-1:0];
				REG_TIMEOUT:      cfg_q.timeout_seconds    <= cfg_wdata[SecW-1:0];
				REG_ARM_PRESSURE: cfg_q.arm_pressure       <= cfg_wdata[PresW-1:0];
				REG_DROP_PERCENT: cfg_q.drop_percent       <= cfg_wdata[PctW-1:0];
				REG_WAIT_LIMIT:   cfg_q.bellows_wait_limit <= cfg_wdata[WaitW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/bts_core.sv @@
`timescale 1ns / 1ps
module bts_core import bts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  poll_t   poll,
	output result_t result
);

	logic             active_q;
	logic [SecW-1:0]  elapsed_q;
	logic [WaitW-1:0] wait_count_q;
	logic             bellows_ready_q;
	logic             armed_q;
	logic [PresW-1:0] previous_pressure_q;

	logic             low;
	logic             high;
	logic [WaitW-1:0] wait_next;
	logic             ready_next;
	logic             sample;
	logic [SecW-1:0]  elapsed_next;
	logic             armed_next;
	logic [ProdW-1:0] cur_scaled;
	logic [ProdW-1:0] prev_scaled;
	logic             burst;
	end_reason_t      why;
	logic             finish;

	always_comb begin
		low          = poll.bellows_adc < cfg.bellows_min_adc;
		high         = poll.bellows_adc > cfg.bellows_max_adc;
		wait_next    = wait_count_q;
		ready_next   = bellows_ready_q;
		if (low) begin
			if (poll.tick && wait_count_q != WaitMax) begin
				wait_next = wait_count_q + WaitW'(1);
			end
		end else begin
			wait_next  = '0;
			ready_next = 1'b1;
		end
		sample       = poll.tick && ready_next;
		elapsed_next = sample ? elapsed_q + SecW'(1) : elapsed_q;
		armed_next   = armed_q || (sample && poll.pressure > cfg.arm_pressure);
		cur_scaled   = ProdW'(poll.pressure) * ProdW'(PctFull);
		prev_scaled  = ProdW'(previous_pressure_q) * ProdW'(cfg.drop_percent);
		burst        = sample && armed_next && cur_scaled < prev_scaled;

		why = END_NONE;
		if (low && wait_next > cfg.bellows_wait_limit) begin
			why = END_BFAULT;
		end else if (burst) begin
			why = END_BURST;
		end else if (sample && armed_next && elapsed_next == cfg.timeout_seconds) begin
			why = END_TIMEOUT;
		end else if (sample && armed_next && poll.abort) begin
			why = END_ABORT;
		end else if (sample && armed_next && elapsed_next > RangeDelay && low) begin
			why = END_LOW;
		end else if (sample && armed_next && elapsed_next > RangeDelay && high) begin
			why = END_HIGH;
		end else if (poll.write_fail) begin
			why = END_WFAIL;
		end else if (poll.abort) begin
			why = END_ABORT;
		end else if (elapsed_next >= cfg.timeout_seconds) begin
			why = END_TIMEOUT;
		end
		finish = why != END_NONE;
	end

	always_comb begin
		result = '0;
		result.end_reason = END_NONE;
		if (!poll.func) begin
			result.running = 1'b1;
		end else if (active_q) begin
			result.running        = !finish;
			result.end_reason     = why;
			result.specimen_valve = !finish && ready_next;
			result.bellows_valve  = !finish;
			result.sample_valid   = sample;
			result.sample_second  = sample ? elapsed_q : '0;
			result.peak_pressure  = burst ? previous_pressure_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q            <= 1'b0;
			elapsed_q           <= '0;
			wait_count_q        <= '0;
			bellows_ready_q     <= 1'b0;
			armed_q             <= 1'b0;
			previous_pressure_q <= '0;
		end else if (step && (!poll.func || (active_q && finish))) begin
			active_q            <= !poll.func;
			elapsed_q           <= '0;
			wait_count_q        <= '0;
			bellows_ready_q     <= 1'b0;
			armed_q             <= 1'b0;
			previous_pressure_q <= '0;
		end else if (step && active_q) begin
			elapsed_q       <= elapsed_next;
			wait_count_q    <= wait_next;
			bellows_ready_q <= ready_next;
			armed_q         <= armed_next;
			if (sample) begin
				previous_pressure_q <= poll.pressure;
			end
		end
	end

endmodule

@@ hdl/burst_test_supervisor.sv @@
`timescale 1ns / 1ps
// Channel   Role          Transfer moves
// poll      sink          func, tick, bellows_adc, pressure, abort, write_fail
// result    source        running, end_reason, valves, sample stamp, peak_pressure
// cfg_*     write port    cfg_index selects a register, cfg_wdata is its new value
//
// One poll per cycle sustained while the result side accepts; a poll passes through the
// input register and the combinational decision logic into the result register.
// Reset clears the test state and loads the register defaults; no clearing pass.
// A stalled result holds the output register; the input register holds one more poll.
module burst_test_supervisor import bts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	bts_poll_if.sink            poll,
	bts_result_if.source        result,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t    cfg;
	poll_t   poll_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (poll.ready) begin
				valid_s1 <= poll.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			poll_s1.func        <= poll.func;
			poll_s1.tick        <= poll.tick;
			poll_s1.bellows_adc <= poll.bellows_adc;
			poll_s1.pressure    <= poll.pressure;
			poll_s1.abort       <= poll.abort;
			poll_s1.write_fail  <= poll.write_fail;
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	bts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.poll   (poll_s1),
		.result (res_comb)
	);

	assign result.valid          = valid_s2;
	assign result.running        = res_s2.running;
	assign result.end_reason     = res_s2.end_reason;
	assign result.specimen_valve = res_s2.specimen_valve;
	assign result.bellows_valve  = res_s2.bellows_valve;
	assign result.sample_valid   = res_s2.sample_valid;
	assign result.sample_second  = res_s2.sample_second;
	assign result.peak_pressure  = res_s2.peak_pressure;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import bts_pkg::*;

	localparam int unsigned AdcTop  = (1 << AdcW) - 1;
	localparam int unsigned PresTop = (1 << PresW) - 1;

	class outcome_board;
		cfg_t             cfg;
		logic             in_test;
		logic [SecW-1:0]  elapsed;
		logic [WaitW-1:0] wait_cnt;
		logic             bel_ready;
		logic             armed;
		logic [PresW-1:0] prev_p;
		result_t          expected_q[$];
		int               errors;
		int               checked;
		int               ends_by[8];

		function void clear_test();
			in_test   = 1'b0;
			elapsed   = '0;
			wait_cnt  = '0;
			bel_ready = 1'b0;
			armed     = 1'b0;
			prev_p    = '0;
		endfunction

		function void reset_model();
			cfg.bellows_min_adc    = '0;
			cfg.bellows_max_adc    = AdcW'(AdcTop);
			cfg.timeout_seconds    = SecW'(30);
			cfg.arm_pressure       = PresW'(10);
			cfg.drop_percent       = PctW'(60);
			cfg.bellows_wait_limit = WaitW'(5);
			clear_test();
			expected_q.delete();
			errors  = 0;
			checked = 0;
			foreach (ends_by[i]) ends_by[i] = 0;
		endfunction

		function end_reason_t keep_first(end_reason_t why, end_reason_t cause);
			return (why == END_NONE) ? cause : why;
		endfunction

		function result_t judge_poll(poll_t p);
			result_t     r;
			end_reason_t why;
			logic        low_bel;
			int unsigned lhs;
			int unsigned rhs;
			r = '0;
			r.end_reason = END_NONE;
			why = END_NONE;
			if (!p.func) begin
				clear_test();
				in_test = 1'b1;
				r.running = 1'b1;
				return r;
			end
			if (!in_test)
				return r;

			low_bel = p.bellows_adc < cfg.bellows_min_adc;
			if (low_bel) begin
				if (p.tick && wait_cnt != WaitMax)
					wait_cnt = wait_cnt + 1'b1;
				if (wait_cnt > cfg.bellows_wait_limit)
					why = keep_first(why, END_BFAULT);
			end else begin
				bel_ready = 1'b1;
				wait_cnt  = '0;
			end

			if (p.tick && bel_ready) begin
				r.sample_valid  = 1'b1;
				r.sample_second = elapsed;
				elapsed = elapsed + 1'b1;
				if (p.pressure > cfg.arm_pressure)
					armed = 1'b1;
				if (armed) begin
					lhs = 32'(p.pressure);
					lhs = lhs * 32'(PctFull);
					rhs = 32'(prev_p);
					rhs = rhs * 32'(cfg.drop_percent);
					if (lhs < rhs) begin
						why = keep_first(why, END_BURST);
						r.peak_pressure = prev_p;
						armed = 1'b0;
					end else begin
						if (elapsed == cfg.timeout_seconds)
							why = keep_first(why, END_TIMEOUT);
						if (p.abort)
							why = keep_first(why, END_ABORT);
						if (elapsed > RangeDelay) begin
							if (low_bel)
								why = keep_first(why, END_LOW);
							if (p.bellows_adc > cfg.bellows_max_adc)
								why = keep_first(why, END_HIGH);
						end
					end
				end
				prev_p = p.pressure;
			end

			if (p.write_fail)
				why = keep_first(why, END_WFAIL);
			if (p.abort)
				why = keep_first(why, END_ABORT);
			if (elapsed >= cfg.timeout_seconds)
				why = keep_first(why, END_TIMEOUT);

			if (why != END_NONE) begin
				clear_test();
			end else begin
				r.running        = 1'b1;
				r.specimen_valve = bel_ready;
				r.bellows_valve  = 1'b1;
			end
			r.end_reason = why;
			return r;
		endfunction

		function void note_poll(poll_t p);
			expected_q.push_back(judge_poll(p));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				if (errors < 100)
					$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with no poll outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			ends_by[want.end_reason]++;
			compare_field("running", 32'(want.running), 32'(got.running));
			compare_field("end_reason", 32'(want.end_reason), 32'(got.end_reason));
			compare_field("specimen_valve", 32'(want.specimen_valve),
				32'(got.specimen_valve));
			compare_field("bellows_valve", 32'(want.bellows_valve), 32'(got.bellows_valve));
			compare_field("sample_valid", 32'(want.sample_valid), 32'(got.sample_valid));
			compare_field("sample_second", 32'(want.sample_second), 32'(got.sample_second));
			compare_field("peak_pressure", 32'(want.peak_pressure), 32'(got.peak_pressure));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	bts_poll_if   pif();
	bts_result_if rif();

	outcome_board board;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int polls_sent = 0;
	int settings_loaded = 0;

	always #5 clk = ~clk;

	burst_test_supervisor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (pif.sink),
		.result    (rif.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	function automatic cfg_t make_cfg(int unsigned min_adc, int unsigned max_adc,
		int unsigned limit_s, int unsigned arm, int unsigned drop, int unsigned waits);
		cfg_t c;
		c.bellows_min_adc    = AdcW'(min_adc);
		c.bellows_max_adc    = AdcW'(max_adc);
		c.timeout_seconds    = SecW'(limit_s);
		c.arm_pressure       = PresW'(arm);
		c.drop_percent       = PctW'(drop);
		c.bellows_wait_limit = WaitW'(waits);
		return c;
	endfunction

	function automatic poll_t mk_poll(bit func, bit tick, int unsigned adc, int unsigned pres,
		bit abort_req, bit wfail);
		poll_t p;
		p.func        = func;
		p.tick        = tick;
		p.bellows_adc = AdcW'(adc);
		p.pressure    = PresW'(pres);
		p.abort       = abort_req;
		p.write_fail  = wfail;
		return p;
	endfunction

	task automatic write_reg(cfg_reg_t r, logic [CfgDataW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic load_config(cfg_t c);
		write_reg(REG_BELLOWS_MIN, CfgDataW'(c.bellows_min_adc));
		write_reg(REG_BELLOWS_MAX, CfgDataW'(c.bellows_max_adc));
		write_reg(REG_TIMEOUT, CfgDataW'(c.timeout_seconds));
		write_reg(REG_ARM_PRESSURE, CfgDataW'(c.arm_pressure));
		write_reg(REG_DROP_PERCENT, CfgDataW'(c.drop_percent));
		write_reg(REG_WAIT_LIMIT, CfgDataW'(c.bellows_wait_limit));
		cfg_we <= 1'b0;
		board.cfg = c;
		settings_loaded++;
	endtask

	task automatic offer_poll(poll_t p);
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			pif.valid <= 1'b0;
			@(posedge clk);
		end
		pif.valid       <= 1'b1;
		pif.func        <= p.func;
		pif.tick        <= p.tick;
		pif.bellows_adc <= p.bellows_adc;
		pif.pressure    <= p.pressure;
		pif.abort       <= p.abort;
		pif.write_fail  <= p.write_fail;
		@(posedge clk);
		while (!pif.ready) @(posedge clk);
		board.note_poll(p);
		polls_sent++;
	endtask

	task automatic drain_results();
		pif.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_burst_test();
		poll_t           p;
		int unsigned     low_polls;
		int unsigned     burst_at;
		int unsigned     ticks_seen;
		int unsigned     n;
		int unsigned     roll;
		int unsigned     cur_p;
		logic [AdcW-1:0] lo;
		logic [AdcW-1:0] hi;
		lo = board.cfg.bellows_min_adc;
		hi = board.cfg.bellows_max_adc;
		p = poll_t'($urandom);
		p.func = 1'b0;
		offer_poll(p);
		low_polls = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 22) : $urandom_range(0, 2);
		burst_at = $urandom_range(2, 45);
		cur_p = $urandom_range(0, 300);
		ticks_seen = 0;
		n = 0;
		while (board.in_test && n < 90) begin
			p = '0;
			p.func = 1'b1;
			p.tick = ($urandom_range(0, 99) < 75);
			roll = $urandom_range(0, 99);
			if ((n < low_polls || roll < 3) && lo != '0)
				p.bellows_adc = AdcW'($urandom_range(0, 32'(lo) - 1));
			else if (roll < 6 && hi != AdcW'(AdcTop))
				p.bellows_adc = AdcW'($urandom_range(32'(hi) + 1, AdcTop));
			else if (roll < 16)
				p.bellows_adc = lo;
			else if (roll < 26)
				p.bellows_adc = hi;
			else
				p.bellows_adc = AdcW'($urandom_range(32'(lo), 32'(hi)));
			if (p.tick) begin
				ticks_seen++;
				if (ticks_seen == burst_at)
					cur_p = cur_p * $urandom_range(0, 70) / 100;
				else
					cur_p = cur_p + $urandom_range(0, 2500);
				if (cur_p > PresTop)
					cur_p = PresTop;
			end
			p.pressure   = PresW'(cur_p);
			p.abort      = ($urandom_range(0, 99) == 0);
			p.write_fail = ($urandom_range(0, 99) == 0);
			offer_poll(p);
			n++;
		end
	endtask

	initial begin : result_side
		result_t got;
		rif.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rif.valid && rif.ready) begin
				got.running        = rif.running;
				got.end_reason     = end_reason_t'(rif.end_reason);
				got.specimen_valve = rif.specimen_valve;
				got.bellows_valve  = rif.bellows_valve;
				got.sample_valid   = rif.sample_valid;
				got.sample_second  = rif.sample_second;
				got.peak_pressure  = rif.peak_pressure;
				board.check_outcome(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				rif.ready <= 1'b0;
			end else begin
				rif.ready <= !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin : poll_side
		cfg_t c;
		int   phase_start;
		int   phase_end;
		bit   held;
		bit   paused;
		board = new;
		board.reset_model();
		held   = 1'b0;
		paused = 1'b0;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_BELLOWS_MIN;
		cfg_wdata        <= '0;
		pif.valid        <= 1'b0;
		pif.func         <= 1'b0;
		pif.tick         <= 1'b0;
		pif.bellows_adc  <= '0;
		pif.pressure     <= '0;
		pif.abort        <= 1'b0;
		pif.write_fail   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_config(make_cfg(1000, 3000, 8, 100, 60, 2));
		offer_poll(mk_poll(1, 1, AdcTop, PresTop, 1, 1));
		offer_poll(mk_poll(0, 0, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 0, 0, 0, 0));
		offer_poll(mk_poll(0, 0, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 0, 2000, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 50, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 200, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 1000, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 500, 0, 0));
		offer_poll(mk_poll(0, 0, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 200, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 300, 0, 0));
		offer_poll(mk_poll(1, 1, 3500, 400, 0, 0));
		offer_poll(mk_poll(0, 0, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 0, 0, 0));
		offer_poll(mk_poll(0, 0, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, 500, 1, 1));
		offer_poll(mk_poll(0, 0, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 2000, PresTop, 0, 1));
		offer_poll(mk_poll(0, 0, 0, 0, 0, 0));
		offer_poll(mk_poll(1, 1, 500, 300, 0, 0));
		offer_poll(mk_poll(1, 1, 1500, 300, 0, 0));
		drain_results();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: c = make_cfg(0, AdcTop, 63, 0, 1, 1);
				1: c = make_cfg(AdcTop, 0, 1, PresTop, 99, 15);
				2: c = make_cfg(800, 3200, 30, 200, 60, 4);
				default: begin
					c = make_cfg($urandom_range(0, 2000), $urandom_range(2000, AdcTop),
						$urandom_range(1, 63),
						($urandom_range(0, 4) == 0) ? PresTop : $urandom_range(0, 3000),
						$urandom_range(1, 99), $urandom_range(1, 15));
				end
			endcase
			load_config(c);
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 64; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 64; end
				default: begin gap_pct = 16; stall_pct = 16; end
			endcase
			phase_start = polls_sent;
			phase_end = 24 + (ph + 1) * 103;
			while (polls_sent < phase_end) begin
				if ($urandom_range(0, 99) < 15)
					offer_poll(poll_t'($urandom));
				else
					run_burst_test();
				// hold the result side off so the poll side backs up
				if (ph == 3 && !held && polls_sent > phase_start + 20) begin
					hold_left = 250;
					held = 1'b1;
				end
				if (ph == 5 && !paused && polls_sent > phase_start + 40) begin
					drain_results();
					paused = 1'b1;
				end
			end
			drain_results();
		end

		gap_pct = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		$display("Sent %0d polls under %0d register settings; %0d results compared.",
			polls_sent, settings_loaded, board.checked);
		$display("Tests ended by burst %0d, timeout %0d, abort %0d, ",
			board.ends_by[END_BURST], board.ends_by[END_TIMEOUT], board.ends_by[END_ABORT],
			"bellows fault %0d, range %0d, write failure %0d",
			board.ends_by[END_BFAULT], board.ends_by[END_LOW] + board.ends_by[END_HIGH],
			board.ends_by[END_WFAIL]);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : run_limit
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ burst_test_supervisor.f @@
hdl/bts_pkg.sv
hdl/bts_if.sv
hdl/bts_cfg.sv
hdl/bts_core.sv
hdl/burst_test_supervisor.sv
verif/tb_top.sv
